FILE: rtl/core/sca_pkg.sv
// Shared types and constants for the seam cost accumulator.
// Used by sca_line_store and seam_cost_accumulator_core; no dependencies.
package sca_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COST_W    = 31;
    localparam int COL_W     = 12;
    localparam int ROW_W     = 16;
    localparam int WIDTH_W   = 13;
    localparam int CFG_W     = 16;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_ROW_COUNT = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             last_col;
        logic             bottom;
        logic             fwd_a;
        logic             fwd_b;
    } s1_ctrl_t;

endpackage

FILE: rtl/core/seam_cost_accumulator_core.sv
// Seam cost accumulator top level: line store, input stage and result register.
// An accepted item is registered in the input stage (s1), then in the result register.
// Throughput: one item per cycle unless m_tready stalls the output; set by the
// two registered line store ports reading middle and right upper neighbors.
// Reset: rst_n asynchronously resets counters, flags, held costs and config; data
// registers and line store are not reset; each entry is written before read.
// Depends on sca_pkg and sca_line_store.
module seam_cost_accumulator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_index,
    input  logic [sca_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [30:0] energy
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [30:0] cumulative_cost
    output logic                          m_tlast,   // frame_last
    output logic [sca_pkg::COL_W-1:0]     m_tuser    // [11:0] seam_start
);

    logic [sca_pkg::WIDTH_W-1:0] row_width_reg;
    logic [sca_pkg::ROW_W-1:0]   row_count_reg;
    logic [sca_pkg::COL_W-1:0]   col_reg;
    logic [sca_pkg::ROW_W-1:0]   row_reg;

    logic                        s1_valid_reg;
    sca_pkg::s1_ctrl_t           s1_reg;
    sca_pkg::s1_ctrl_t           s1_next;
    logic [sca_pkg::COST_W-1:0]  s1_energy_reg;
    logic [sca_pkg::COST_W-1:0]  byp_reg;

    logic [sca_pkg::COST_W-1:0]  held_left_reg;
    logic [sca_pkg::COST_W-1:0]  best_cost_reg;
    logic [sca_pkg::COL_W-1:0]   best_col_reg;

    logic                        out_valid_reg;
    logic [sca_pkg::COST_W-1:0]  out_cost_reg;
    logic                        out_last_reg;
    logic [sca_pkg::COL_W-1:0]   out_seam_reg;

    logic [sca_pkg::WIDTH_W-1:0] width_eff;
    logic [sca_pkg::ROW_W-1:0]   rows_eff;
    logic                        in_last_col;
    logic                        in_bottom;
    logic [sca_pkg::COL_W-1:0]   col_plus;
    logic                        en;
    logic                        accept;
    logic                        wr_en;

    logic [sca_pkg::COST_W-1:0]  rd_a;
    logic [sca_pkg::COST_W-1:0]  rd_b;
    logic [sca_pkg::COST_W-1:0]  mid;
    logic [sca_pkg::COST_W-1:0]  left;
    logic [sca_pkg::COST_W-1:0]  right;
    logic [sca_pkg::COST_W-1:0]  min_lm;
    logic [sca_pkg::COST_W-1:0]  min_all;
    logic [sca_pkg::COST_W:0]    sum;
    logic [sca_pkg::COST_W-1:0]  cost;
    logic [sca_pkg::COST_W-1:0]  base_cost;
    logic [sca_pkg::COL_W-1:0]   base_col;
    logic [sca_pkg::COST_W-1:0]  best_cost_next;
    logic [sca_pkg::COL_W-1:0]   best_col_next;
    logic                        frame_end;

    always_comb
    begin
        if (row_width_reg == '0)
        begin
            width_eff = sca_pkg::WIDTH_W'(1);
        end
        else if (row_width_reg > sca_pkg::WIDTH_W'(sca_pkg::MAX_WIDTH))
        begin
            width_eff = sca_pkg::WIDTH_W'(sca_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = row_width_reg;
        end
        rows_eff = (row_count_reg == '0) ? sca_pkg::ROW_W'(1) : row_count_reg;
    end

    assign col_plus    = col_reg + sca_pkg::COL_W'(1);
    assign in_last_col = ({1'b0, col_reg} + sca_pkg::WIDTH_W'(1)) >= width_eff;
    assign in_bottom   = ({1'b0, row_reg} + 17'd1) >= {1'b0, rows_eff};

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || en;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = en && s1_valid_reg;

    always_comb
    begin
        s1_next.col       = col_reg;
        s1_next.first_row = (row_reg == '0);
        s1_next.last_col  = in_last_col;
        s1_next.bottom    = in_bottom;
        s1_next.fwd_a     = wr_en && (s1_reg.col == col_reg);
        s1_next.fwd_b     = wr_en && (s1_reg.col == col_plus);
    end

    sca_line_store u_line_store
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (s1_reg.col[sca_pkg::ADDR_W-1:0]),
        .wr_data   (cost),
        .rd_en     (accept),
        .rd_addr_a (col_reg[sca_pkg::ADDR_W-1:0]),
        .rd_addr_b (col_plus[sca_pkg::ADDR_W-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_comb
    begin
        mid     = s1_reg.fwd_a ? byp_reg : rd_a;
        left    = (s1_reg.col == '0) ? mid : held_left_reg;
        right   = s1_reg.last_col ? mid : (s1_reg.fwd_b ? byp_reg : rd_b);
        min_lm  = (mid < left) ? mid : left;
        min_all = (right < min_lm) ? right : min_lm;
        sum     = {1'b0, s1_energy_reg} + {1'b0, min_all};
        if (s1_reg.first_row)
        begin
            cost = s1_energy_reg;
        end
        else if (sum >= {1'b0, sca_pkg::COST_MAX})
        begin
            cost = sca_pkg::COST_MAX;
        end
        else
        begin
            cost = sum[sca_pkg::COST_W-1:0];
        end

        base_cost = (s1_reg.col == '0) ? sca_pkg::COST_MAX : best_cost_reg;
        base_col  = (s1_reg.col == '0) ? '0 : best_col_reg;
        if (cost < base_cost)
        begin
            best_cost_next = cost;
            best_col_next  = s1_reg.col;
        end
        else
        begin
            best_cost_next = base_cost;
            best_col_next  = base_col;
        end
        frame_end = s1_reg.bottom && s1_reg.last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= sca_pkg::WIDTH_W'(sca_pkg::MAX_WIDTH);
            row_count_reg <= sca_pkg::ROW_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_wr_index)
                sca_pkg::REG_ROW_WIDTH: row_width_reg <= cfg_wr_data[sca_pkg::WIDTH_W-1:0];
                sca_pkg::REG_ROW_COUNT: row_count_reg <= cfg_wr_data[sca_pkg::ROW_W-1:0];
                default:                row_count_reg <= row_count_reg;
            endcase
        end
    end

    // advance column on every accepted item, and row at the last column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_reg       <= s1_next;
                if (in_last_col)
                begin
                    col_reg <= '0;
                    row_reg <= in_bottom ? '0 : row_reg + sca_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_plus;
                end
            end
            else if (en)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_energy_reg <= s_tdata[sca_pkg::COST_W-1:0];
            byp_reg       <= cost;
        end
        if (wr_en)
        begin
            out_cost_reg <= cost;
            out_last_reg <= frame_end;
            out_seam_reg <= frame_end ? best_col_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_left_reg <= '0;
            best_cost_reg <= sca_pkg::COST_MAX;
            best_col_reg  <= '0;
        end
        else
        begin
            if (en)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (wr_en)
            begin
                held_left_reg <= s1_reg.first_row ? '0 : mid;
                if (frame_end)
                begin
                    best_cost_reg <= sca_pkg::COST_MAX;
                    best_col_reg  <= '0;
                end
                else if (s1_reg.bottom)
                begin
                    best_cost_reg <= best_cost_next;
                    best_col_reg  <= best_col_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_cost_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_seam_reg;

    a_seam_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == '0))
        else $error("seam_start nonzero off frame end");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last_col) |=> (col_reg == '0))
        else $error("column counter did not wrap at row end");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("input stage changed while stalled");

    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item missing from input stage");

endmodule

FILE: rtl/core/sca_line_store.sv
// Previous-row cost store: one write port, two registered read ports.
// Depends on sca_pkg for depth and widths.
module sca_line_store
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [sca_pkg::ADDR_W-1:0]    wr_addr,
    input  logic [sca_pkg::COST_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [sca_pkg::ADDR_W-1:0]    rd_addr_a,
    input  logic [sca_pkg::ADDR_W-1:0]    rd_addr_b,
    output logic [sca_pkg::COST_W-1:0]    rd_data_a,
    output logic [sca_pkg::COST_W-1:0]    rd_data_b
);

    logic [sca_pkg::COST_W-1:0] mem [sca_pkg::MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
